/* rtl/assert_macros.svh */
// Assertion macros for the divider search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/pllds_pkg.sv */
// Shared types, constants and helper functions for the divider search.
package pllds_pkg;
	localparam int KHZ_W = 22;
	localparam int HZ_W = 32;
	localparam int DEF_MAX_MULT = 64;
	localparam int DEF_MAX_DIV_IN = 80;
	localparam int DEF_MAX_DIV_OUT = 128;
	localparam logic [KHZ_W-1:0] RST_PFD_MIN = 22'd10000;
	localparam logic [KHZ_W-1:0] RST_PFD_MAX = 22'd300000;
	localparam logic [KHZ_W-1:0] RST_VCO_MIN = 22'd600000;
	localparam logic [KHZ_W-1:0] RST_VCO_MAX = 22'd1200000;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PFD_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PFD_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX = 3'd3;

	// divider unit widths: 48-bit dividend, 32-bit divisor
	localparam int DVD_W = 48;
	localparam int DVS_W = 32;

	typedef struct packed {
		logic [HZ_W-1:0] ref_rate_hz;
		logic [HZ_W-1:0] target_rate_hz;
	} in_word_t;

	typedef struct packed {
		logic        valid_res;
		logic [6:0]  div_in;
		logic [6:0]  mult;
		logic [7:0]  div_out;
		logic [21:0] achieved_khz;
		logic [31:0] filter_word;
		logic [12:0] out_low_high;
		logic [7:0]  out_edge_nocount;
		logic [13:0] in_div_word;
		logic [12:0] fb_low_high;
		logic [7:0]  fb_edge_nocount;
	} out_word_t;

	// divider handshake
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             busy;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	// loop filter word by multiplier minus one
	function automatic logic [31:0] filter_for(input logic [6:0] i);
		logic [31:0] w;
		if (i == 7'd0) w = 32'h01001990;
		else if (i == 7'd1) w = 32'h01001190;
		else if (i == 7'd2) w = 32'h01009890;
		else if (i == 7'd3) w = 32'h01001890;
		else if (i == 7'd4) w = 32'h01008890;
		else if (i <= 7'd8) w = 32'h01009090;
		else if (i <= 7'd11) w = 32'h01000890;
		else if (i == 7'd12) w = 32'h08009090;
		else if (i <= 7'd22) w = 32'h01001090;
		else if (i <= 7'd36) w = 32'h01008090;
		else if (i <= 7'd46) w = 32'h08001090;
		else w = 32'h08008090;
		return w;
	endfunction

	// divider word pieces: {high, low} and {edge, nocount}
	function automatic logic [12:0] lo_hi(input logic [7:0] n);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {1'b0, n[7:1]};
		lo = n - hi;
		return {hi[6:0], 6'b0} | {5'b0, lo};
	endfunction

	function automatic logic [1:0] edge_nc(input logic [7:0] n);
		return {n[0], n == 8'd1};
	endfunction
endpackage

/* rtl/pll_divider_search_top.sv */
// Top level: registers, search sequencer and result word.
// Each item runs 6 divisions for bounds on the shared radix-2 divider, plus 2 per
// multiplier and 3 per candidate pair, each pair followed by a compare state;
// requests with a zero rate or zero limit end after the two rate divisions.
// Throughput: one item at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// Reset: asynchronous active low; limits return to their defaults, no item held.
`include "assert_macros.svh"
module pll_divider_search_top
	import pllds_pkg::*;
#(
	parameter int MAX_MULT = DEF_MAX_MULT,
	parameter int MAX_DIV_IN = DEF_MAX_DIV_IN,
	parameter int MAX_DIV_OUT = DEF_MAX_DIV_OUT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [KHZ_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data
);
	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_FIN   = 14'b00000000000010,
		ST_FOUT  = 14'b00000000000100,
		ST_DMIN  = 14'b00000000001000,
		ST_DMAX  = 14'b00000000010000,
		ST_MMIN  = 14'b00000000100000,
		ST_MMAX  = 14'b00000001000000,
		ST_LOD   = 14'b00000010000000,
		ST_HID   = 14'b00000100000000,
		ST_VCO   = 14'b00001000000000,
		ST_DOUT  = 14'b00010000000000,
		ST_ACH   = 14'b00100000000000,
		ST_EVAL  = 14'b01000000000000,
		ST_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic   issue_q;

	logic [KHZ_W-1:0] pfd_min_q, pfd_max_q, vco_min_q, vco_max_q;
	logic [HZ_W-1:0]  ref_hz_q, tgt_hz_q;
	logic [22:0]      fin_q, fout_q;
	logic [7:0]       d_min_q, d_max_q, m_q, m_max_q, d_q, hi_d_q, dout_q;
	logic [7:0]       bd_q, bm_q, bo_q;
	logic [40:0]      fvco_q;
	logic [40:0]      f_q, best_f_q;
	logic [41:0]      best_err_q;
	logic             found_q;
	out_word_t        res_q;
	logic             res_valid_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic [DVD_W-1:0] q;
	logic [DVS_W-1:0] r;
	logic [41:0]      err;
	logic [40:0]      dividend_c;
	logic [DVS_W-1:0] divisor_c;
	logic [40:0]      qsat;
	logic [12:0]      in_lh;

	pllds_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign q = drsp.quot;
	assign r = drsp.rem;
	assign qsat = (q[DVD_W-1:41] != '0) ? '1 : q[40:0];
	assign in_lh = lo_hi(bd_q);

	// operands per state
	always_comb begin
		dividend_c = '0;
		divisor_c = 32'd1;
		case (state_q)
			ST_FIN: begin dividend_c = 41'(ref_hz_q); divisor_c = 32'd1000; end
			ST_FOUT: begin dividend_c = 41'(tgt_hz_q); divisor_c = 32'd1000; end
			ST_DMIN: begin dividend_c = 41'(fin_q); divisor_c = 32'(pfd_max_q); end
			ST_DMAX: begin dividend_c = 41'(fin_q); divisor_c = 32'(pfd_min_q); end
			ST_MMIN: begin dividend_c = 41'(vco_min_q); divisor_c = 32'(fin_q); end
			ST_MMAX: begin
				dividend_c = 41'(vco_max_q) * 41'(d_max_q);
				divisor_c = 32'(fin_q);
			end
			ST_LOD: begin dividend_c = 41'(fin_q) * 41'(m_q); divisor_c = 32'(vco_max_q); end
			ST_HID: begin dividend_c = 41'(fin_q) * 41'(m_q); divisor_c = 32'(vco_min_q); end
			ST_VCO: begin dividend_c = 41'(fin_q) * 41'(m_q); divisor_c = 32'(d_q); end
			ST_DOUT: begin
				dividend_c = fvco_q + 41'(fout_q[22:1]);
				divisor_c = 32'(fout_q);
			end
			ST_ACH: begin dividend_c = fvco_q; divisor_c = 32'(dout_q); end
			default: ;
		endcase
	end

	assign dreq.start = issue_q;
	assign dreq.dividend = DVD_W'(dividend_c);
	assign dreq.divisor = divisor_c;

	assign err = (f_q >= 41'(fout_q)) ? 42'(f_q - 41'(fout_q)) : 42'(41'(fout_q) - f_q);

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = res_valid_q;
	assign out_data = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfd_min_q <= RST_PFD_MIN;
			pfd_max_q <= RST_PFD_MAX;
			vco_min_q <= RST_VCO_MIN;
			vco_max_q <= RST_VCO_MAX;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PFD_MIN: pfd_min_q <= cfg_data;
				REG_PFD_MAX: pfd_max_q <= cfg_data;
				REG_VCO_MIN: vco_min_q <= cfg_data;
				REG_VCO_MAX: vco_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			issue_q <= 1'b0;
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					ref_hz_q <= in_data.ref_rate_hz;
					tgt_hz_q <= in_data.target_rate_hz;
					found_q <= 1'b0;
					state_q <= ST_FIN;
					issue_q <= 1'b1;
				end
				ST_FIN: if (drsp.done) begin
					fin_q <= q[22:0];
					state_q <= ST_FOUT;
					issue_q <= 1'b1;
				end
				ST_FOUT: if (drsp.done) begin
					fout_q <= q[22:0];
					best_err_q <= 42'(q[22:0]) + 42'd1;
					if (fin_q == '0 || q[22:0] == '0 || pfd_min_q == '0 ||
					    pfd_max_q == '0 || vco_min_q == '0 || vco_max_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DMIN;
						issue_q <= 1'b1;
					end
				end
				ST_DMIN: if (drsp.done) begin
					// ceil, at least 1; huge values saturate
					if (q[DVD_W-1:8] != '0) d_min_q <= 8'hFF;
					else if (q[7:0] == 8'd0) d_min_q <= 8'd1;
					else if (r != '0 && q[7:0] != 8'hFF) d_min_q <= q[7:0] + 8'd1;
					else d_min_q <= q[7:0];
					state_q <= ST_DMAX;
					issue_q <= 1'b1;
				end
				ST_DMAX: if (drsp.done) begin
					d_max_q <= (q > DVD_W'(MAX_DIV_IN)) ? 8'(MAX_DIV_IN) : q[7:0];
					state_q <= ST_MMIN;
					issue_q <= 1'b1;
				end
				ST_MMIN: if (drsp.done) begin
					// m_min = ceil(vco_min/fin)*d_min, compared against m_max and used as the first multiplier
					logic [DVD_W:0] c;
					logic [DVD_W+8:0] mm;
					c = {1'b0, q} + (DVD_W+1)'(r != '0);
					mm = {8'b0, c} * {{DVD_W+1{1'b0}}, d_min_q};
					if (mm > (DVD_W+9)'(MAX_MULT)) m_q <= 8'hFF;
					else m_q <= (mm[7:0] == 8'd0) ? 8'd1 : mm[7:0];
					state_q <= ST_MMAX;
					issue_q <= 1'b1;
				end
				ST_MMAX: if (drsp.done) begin
					m_max_q <= (q > DVD_W'(MAX_MULT)) ? 8'(MAX_MULT) : q[7:0];
					if (m_q > ((q > DVD_W'(MAX_MULT)) ? 8'(MAX_MULT) : q[7:0])) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LOD;
						issue_q <= 1'b1;
					end
				end
				ST_LOD: if (drsp.done) begin
					if (q + DVD_W'(r != '0) > DVD_W'(d_min_q))
						d_q <= q[7:0] + ((r != '0) ? 8'd1 : 8'd0);
					else d_q <= d_min_q;
					state_q <= ST_HID;
					issue_q <= 1'b1;
				end
				ST_HID: if (drsp.done) begin
					hi_d_q <= (q > DVD_W'(d_max_q)) ? d_max_q : q[7:0];
					if (d_q > ((q > DVD_W'(d_max_q)) ? d_max_q : q[7:0])) begin
						if (m_q >= m_max_q) state_q <= ST_OUT;
						else begin
							m_q <= m_q + 8'd1;
							state_q <= ST_LOD;
							issue_q <= 1'b1;
						end
					end else begin
						state_q <= ST_VCO;
						issue_q <= 1'b1;
					end
				end
				ST_VCO: if (drsp.done) begin
					fvco_q <= q[40:0];
					state_q <= ST_DOUT;
					issue_q <= 1'b1;
				end
				ST_DOUT: if (drsp.done) begin
					if (q == '0) dout_q <= 8'd1;
					else if (q > DVD_W'(MAX_DIV_OUT)) dout_q <= 8'(MAX_DIV_OUT);
					else dout_q <= q[7:0];
					state_q <= ST_ACH;
					issue_q <= 1'b1;
				end
				ST_ACH: if (drsp.done) begin
					f_q <= qsat;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (err < best_err_q) begin
						best_err_q <= err;
						best_f_q <= f_q;
						bd_q <= d_q;
						bm_q <= m_q;
						bo_q <= dout_q;
						found_q <= 1'b1;
					end
					if (err < best_err_q && err == '0) state_q <= ST_OUT;
					else if (d_q < hi_d_q) begin
						d_q <= d_q + 8'd1;
						state_q <= ST_VCO;
						issue_q <= 1'b1;
					end else if (m_q < m_max_q) begin
						m_q <= m_q + 8'd1;
						state_q <= ST_LOD;
						issue_q <= 1'b1;
					end else state_q <= ST_OUT;
				end
				ST_OUT: if (!res_valid_q || !out_stall) begin
					res_valid_q <= 1'b1;
					res_q <= '0;
					if (found_q) begin
						res_q.valid_res <= 1'b1;
						res_q.div_in <= bd_q[6:0];
						res_q.mult <= bm_q[6:0];
						res_q.div_out <= bo_q;
						res_q.achieved_khz <= best_f_q[21:0];
						res_q.filter_word <= filter_for(bm_q[6:0] - 7'd1);
						res_q.out_low_high <= lo_hi(bo_q);
						res_q.out_edge_nocount <= {edge_nc(bo_q), 6'b0};
						res_q.in_div_word <= {edge_nc(bd_q), in_lh[11:0]};
						res_q.fb_low_high <= lo_hi(bm_q);
						res_q.fb_edge_nocount <= {edge_nc(bm_q), 6'b0};
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_div_start_idle, clk, arst_n, dreq.start |-> !drsp.busy, "divider restarted while busy")
	`ASSERT_CLK(a_one_hot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "result changed under stall")
	`ASSERT_CLK(a_invalid_zero, clk, arst_n, (out_valid && !out_data.valid_res) |-> (out_data.mult == '0 && out_data.div_in == '0), "invalid result not zero")
endmodule

/* rtl/pllds_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module pllds_div
	import pllds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quot_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;

	// shift in next dividend bit and try subtract
	assign trial = {rem_q, quot_q[DVD_W-1]};
	assign diff = {1'b0, trial} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quot_q <= {quot_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DVS_W-1:0];
				quot_q <= {quot_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;
	assign rsp.rem = rem_q;
endmodule

/* verif/pll_divider_search_checker.sv */
// Checker for the divider search: tracks the limit registers, predicts each result, compares.
module pll_divider_search_checker
	import pllds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [KHZ_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_word_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_word_t            out_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [KHZ_W-1:0] pfd_min, pfd_max, vco_min, vco_max;
	out_word_t        expected_words[$];

	function automatic longint unsigned ceil_quot(longint unsigned a, longint unsigned b);
		return (a + b - 1) / b;
	endfunction

	// loop filter word by multiplier minus one
	function automatic logic [31:0] loop_filter(longint unsigned i);
		if (i == 0) return 32'h01001990;
		if (i == 1) return 32'h01001190;
		if (i == 2) return 32'h01009890;
		if (i == 3) return 32'h01001890;
		if (i == 4) return 32'h01008890;
		if (i <= 8) return 32'h01009090;
		if (i <= 11) return 32'h01000890;
		if (i == 12) return 32'h08009090;
		if (i <= 22) return 32'h01001090;
		if (i <= 36) return 32'h01008090;
		if (i <= 46) return 32'h08001090;
		return 32'h08008090;
	endfunction

	// exhaustive m/d search, first strictly better candidate wins, exact match stops it
	function automatic out_word_t search_dividers(in_word_t w);
		out_word_t       r;
		longint unsigned fin, fout, best_err, best_f, bd, bm, bo;
		longint unsigned d_lo, d_hi, m_lo, m_hi, m, d, lo_d, hi_d, fvco, dout, f, err;
		longint unsigned hi, lo;
		bit              found, done;
		r = '0;
		found = 0;
		done = 0;
		best_f = 0;
		bd = 0;
		bm = 0;
		bo = 0;
		fin = longint'(w.ref_rate_hz) / 1000;
		fout = longint'(w.target_rate_hz) / 1000;
		if (fin == 0 || fout == 0 || pfd_min == 0 || pfd_max == 0 ||
			vco_min == 0 || vco_max == 0)
			return r;
		best_err = fout + 1;
		d_lo = ceil_quot(fin, pfd_max);
		if (d_lo < 1) d_lo = 1;
		d_hi = fin / pfd_min;
		if (d_hi > DEF_MAX_DIV_IN) d_hi = DEF_MAX_DIV_IN;
		m_lo = ceil_quot(vco_min, fin) * d_lo;
		if (m_lo < 1) m_lo = 1;
		m_hi = longint'(vco_max) * d_hi / fin;
		if (m_hi > DEF_MAX_MULT) m_hi = DEF_MAX_MULT;
		for (m = m_lo; m <= m_hi && !done; m++) begin
			lo_d = ceil_quot(fin * m, vco_max);
			hi_d = fin * m / vco_min;
			if (lo_d < d_lo) lo_d = d_lo;
			if (hi_d > d_hi) hi_d = d_hi;
			for (d = lo_d; d <= hi_d && !done; d++) begin
				fvco = fin * m / d;
				dout = (fvco + fout / 2) / fout;
				if (dout < 1) dout = 1;
				if (dout > DEF_MAX_DIV_OUT) dout = DEF_MAX_DIV_OUT;
				f = fvco / dout;
				err = (f >= fout) ? f - fout : fout - f;
				if (err < best_err) begin
					best_err = err;
					best_f = f;
					bd = d;
					bm = m;
					bo = dout;
					found = 1;
					if (err == 0) done = 1;
				end
			end
		end
		if (!found)
			return r;
		r.valid_res = 1'b1;
		r.div_in = bd[6:0];
		r.mult = bm[6:0];
		r.div_out = bo[7:0];
		r.achieved_khz = best_f[21:0];
		r.filter_word = loop_filter(bm - 1);
		hi = bo / 2;
		lo = bo - hi;
		r.out_low_high = 13'((hi << 6) | lo);
		r.out_edge_nocount = {bo[0], bo == 1, 6'b0};
		hi = bd / 2;
		lo = bd - hi;
		r.in_div_word = 14'((bd[0] << 13) | ((bd == 1) << 12) | (hi << 6) | lo);
		hi = bm / 2;
		lo = bm - hi;
		r.fb_low_high = 13'((hi << 6) | lo);
		r.fb_edge_nocount = {bm[0], bm == 1, 6'b0};
		return r;
	endfunction

	function automatic int field_ok(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v == act_v) return 0;
		$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		return 1;
	endfunction

	assign pending = expected_words.size();

	// register shadow, prediction on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		int        bad;
		if (!arst_n) begin
			pfd_min <= RST_PFD_MIN;
			pfd_max <= RST_PFD_MAX;
			vco_min <= RST_VCO_MIN;
			vco_max <= RST_VCO_MAX;
			fail_count <= 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IDX_W'(REG_PFD_MIN): pfd_min <= cfg_data;
					CFG_IDX_W'(REG_PFD_MAX): pfd_max <= cfg_data;
					CFG_IDX_W'(REG_VCO_MIN): vco_min <= cfg_data;
					CFG_IDX_W'(REG_VCO_MAX): vco_max <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_words.push_back(search_dividers(in_data));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected output word %h", out_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					bad = 0;
					bad += field_ok("valid_res", e.valid_res, out_data.valid_res);
					bad += field_ok("div_in", e.div_in, out_data.div_in);
					bad += field_ok("mult", e.mult, out_data.mult);
					bad += field_ok("div_out", e.div_out, out_data.div_out);
					bad += field_ok("achieved_khz", e.achieved_khz, out_data.achieved_khz);
					bad += field_ok("filter_word", e.filter_word, out_data.filter_word);
					bad += field_ok("out_low_high", e.out_low_high, out_data.out_low_high);
					bad += field_ok("out_edge_nocount", e.out_edge_nocount,
						out_data.out_edge_nocount);
					bad += field_ok("in_div_word", e.in_div_word, out_data.in_div_word);
					bad += field_ok("fb_low_high", e.fb_low_high, out_data.fb_low_high);
					bad += field_ok("fb_edge_nocount", e.fb_edge_nocount,
						out_data.fb_edge_nocount);
					fail_count <= fail_count + bad;
				end
			end
		end
	end
endmodule

/* verif/testbench.sv */
// Testbench top: clock, reset, limit writes, request and result traffic, verdict.
module testbench;
	import pllds_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [KHZ_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_word_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_data;
	int                   fail_count;
	int                   pending;
	int                   idle_cycles = 0;
	bit                   hold_off_req = 0;
	bit                   quiet_rx = 0;

	pll_divider_search_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	pll_divider_search_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// watchdog: cycles with no word moving on any port
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side stall pattern, with one long hold-off on request
	initial begin
		int n;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			n = quiet_rx ? 0 : gap_len();
			if (hold_off_req && !held) begin
				n = 400;
				held = 1;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [KHZ_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(logic [31:0] ref_hz, logic [31:0] tgt_hz);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{ref_rate_hz: ref_hz, target_rate_hz: tgt_hz};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait until every result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// a request whose target is built from a random m/d/o applied to the reference rate
	task automatic send_reachable(int fin_lo, int fin_hi);
		longint unsigned fin, tgt;
		fin = $urandom_range(fin_lo, fin_hi);
		tgt = fin * $urandom_range(1, 64) / $urandom_range(1, 4) / $urandom_range(1, 20);
		if (tgt == 0) tgt = 1;
		send_request(32'(fin * 1000 + $urandom_range(0, 999)),
			32'(tgt * 1000 + $urandom_range(0, 999)));
	endtask

	task automatic random_phase(int count, int fin_lo, int fin_hi);
		int k;
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (k < 10)
				send_request($urandom_range(0, 999), $urandom());
			else if (k < 15)
				send_request(32'($urandom_range(fin_lo, fin_hi) * 1000), $urandom_range(0, 999));
			else if (k < 35)
				send_request(32'($urandom_range(fin_lo, fin_hi) * 1000 + $urandom_range(0, 999)),
					$urandom());
			else
				send_reachable(fin_lo, fin_hi);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults: zero rates, extremes of both fields, typical requests
		send_request(32'd0, 32'd125000000);
		send_request(32'd100000000, 32'd0);
		send_request(32'd999, 32'd999);
		send_request(32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(32'd100000000, 32'd125000000);
		send_request(32'd100000000, 32'd1000);
		send_request(32'd20000000, 32'd150000000);
		send_request(32'd10000000, 32'd50000000);
		send_request(32'd33333333, 32'd74250000);
		drain();

		// zero limit register
		write_limit(REG_PFD_MIN, '0);
		end_writes();
		send_request(32'd100000000, 32'd125000000);
		drain();

		// unreachable bounds: top of the pfd range and the bottom of the vco range
		write_limit(REG_PFD_MIN, 22'h3FFFFF);
		write_limit(REG_PFD_MAX, 22'h3FFFFF);
		write_limit(REG_VCO_MIN, 22'd1);
		write_limit(REG_VCO_MAX, 22'd1);
		write_limit(3'd5, 22'd12345);
		end_writes();
		send_request(32'd100000000, 32'd125000000);
		send_request(32'd50000000, 32'd1000);
		drain();

		// narrow vco window keeps the search short; long result hold-off here
		write_limit(REG_PFD_MIN, 22'd20000);
		write_limit(REG_PFD_MAX, 22'd60000);
		write_limit(REG_VCO_MIN, 22'd600000);
		write_limit(REG_VCO_MAX, 22'd800000);
		end_writes();
		hold_off_req = 1;
		random_phase(50, 20000, 60000);
		drain();

		// quiet receiver stretch, wider limits
		quiet_rx = 1;
		write_limit(REG_PFD_MIN, 22'd10000);
		write_limit(REG_PFD_MAX, 22'd300000);
		write_limit(REG_VCO_MIN, 22'd800000);
		write_limit(REG_VCO_MAX, 22'd1000000);
		end_writes();
		random_phase(15, 10000, 40000);
		quiet_rx = 0;
		random_phase(35, 10000, 40000);
		drain();

		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/pllds_pkg.sv
rtl/pllds_div.sv
rtl/pll_divider_search_top.sv
verif/pll_divider_search_checker.sv
verif/testbench.sv
